[rtl/core/wts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the world-to-screen projection core.
// No dependencies.
package wts_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_W         = 48;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 64;
	localparam int SCR_W         = 14;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_LO = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_HI = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_HI = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WROW_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WROW_HI = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 4'd7;

	localparam logic [SCR_W-1:0] SCR_W_RST = 14'd1920;
	localparam logic [SCR_W-1:0] SCR_H_RST = 14'd1080;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;
	localparam int BEHIND_SCALE = 100000;
	// truncated quotients of the output limits by the behind scale
	localparam logic signed [31:0] BEHIND_HI = 32'sd1407374883;
	localparam logic signed [31:0] BEHIND_LO = -32'sd1407374883;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} point_t;

	typedef struct packed {
		logic                    in_front;
		logic signed [OUT_W-1:0] screen_x;
		logic signed [OUT_W-1:0] screen_y;
	} pixel_t;

endpackage

[rtl/core/world_to_screen_projection_core.sv]
`timescale 1ns / 1ps
// World-to-screen projection: matrix rows, perspective divide, viewport map.
// Depends on wts_pkg.

// One point enters per cycle and one result leaves per cycle while the output
// is not stalled. Stages: one multiply stage, one dot-product sum stage, one
// stage for the behind-viewer test and divider setup, 50 restoring-division
// stages (one quotient bit each, x and y in parallel), one viewport multiply
// stage and the output register. The whole pipeline advances together
// whenever the output register is empty or its beat is taken, so a stalled
// result holds every stage in place and nothing is lost or repeated. A point
// whose w is at or below ceil(0.001 * 2^FRAC_BITS) is reported with in_front
// low and clip x,y scaled by 100000 and saturated. Configuration writes take
// effect at once and are meant to be made while the pipeline is empty.
module world_to_screen_projection_core #(
	parameter int FRAC_BITS = wts_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wts_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wts_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 point_valid,
	output logic                                 point_ready,
	input  wts_pkg::point_t                      point,
	output logic                                 screen_valid,
	input  logic                                 screen_ready,
	output wts_pkg::pixel_t                      screen
);
	import wts_pkg::*;

	localparam int CW  = 67 - FRAC_BITS;          // clip value width
	localparam int QB  = 50;                      // quotient bits up to the clamp
	localparam int RW  = CW + QB;                 // remainder width
	localparam int MW  = QB + 1 + SCR_W + 1;      // viewport product width
	localparam int SW  = MW + 2;                  // viewport sum width
	localparam logic signed [CW-1:0] W_MIN = CW'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);
	localparam logic [QB-1:0] Q_LIM = QB'(1) << (QB - 1);

	// configuration
	logic [CFG_DATA_W-1:0] mat_q [6];
	logic [SCR_W-1:0]      sw_q, sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) mat_q[i] <= '0;
			sw_q <= SCR_W_RST;
			sh_q <= SCR_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0_LO: mat_q[0] <= cfg_data;
				REG_ROW0_HI: mat_q[1] <= cfg_data;
				REG_ROW1_LO: mat_q[2] <= cfg_data;
				REG_ROW1_HI: mat_q[3] <= cfg_data;
				REG_WROW_LO: mat_q[4] <= cfg_data;
				REG_WROW_HI: mat_q[5] <= cfg_data;
				REG_SCR_W:   sw_q     <= cfg_data[SCR_W-1:0];
				REG_SCR_H:   sh_q     <= cfg_data[SCR_W-1:0];
				default: ;   // drop writes beyond the register list
			endcase
		end
	end

	logic signed [31:0] coef [3][3];
	logic signed [31:0] trans [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = mat_q[2*r][31:0];
			coef[r][1] = mat_q[2*r][63:32];
			coef[r][2] = mat_q[2*r+1][31:0];
			trans[r]   = mat_q[2*r+1][63:32];
		end
	end

	// the whole pipe moves when the output register can take a beat
	logic adv;
	assign adv         = !screen_valid || screen_ready;
	assign point_ready = adv;

	// stage 1: nine products
	logic               v_s1;
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] pin [3];
	assign pin[0] = point.world_x;
	assign pin[1] = point.world_y;
	assign pin[2] = point.world_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= point_valid;
	end
	always_ff @(posedge clk) begin
		if (adv)
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= coef[r][c] * pin[c];
	end

	// stage 2: floor each product, sum, add translation
	logic               v_s2;
	logic signed [CW-1:0] clip_s2 [3];
	logic signed [CW-1:0] clip_d [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			clip_d[r] = CW'(trans[r]);
			for (int c = 0; c < 3; c++)
				clip_d[r] = clip_d[r] + CW'($signed(prod_s1[r][c][63:FRAC_BITS]));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) for (int r = 0; r < 3; r++) clip_s2[r] <= clip_d[r];
	end

	// stage 3: behind test, behind outputs, divider setup
	logic                    v_s3, front_s3, negx_s3, negy_s3, ovx_s3, ovy_s3;
	logic [CW-2:0]           d_s3;
	logic [RW-1:0]           rx_s3, ry_s3;
	logic signed [OUT_W-1:0] bx_s3, by_s3;

	function automatic logic signed [OUT_W-1:0] behind_scale(input logic signed [CW-1:0] c);
		logic signed [OUT_W-1:0] c48;
		c48 = OUT_W'(c);
		if (c > CW'(BEHIND_HI)) return OUT_MAX;
		if (c < CW'(BEHIND_LO)) return OUT_MIN;
		return c48 * 48'sd100000;
	endfunction

	logic [CW-1:0] ax_d, ay_d;
	logic [RW-1:0] nx_d, ny_d, dq_d;
	always_comb begin
		ax_d = clip_s2[0][CW-1] ? CW'(-clip_s2[0]) : CW'(clip_s2[0]);
		ay_d = clip_s2[1][CW-1] ? CW'(-clip_s2[1]) : CW'(clip_s2[1]);
		nx_d = RW'({ax_d, {FRAC_BITS{1'b0}}});
		ny_d = RW'({ay_d, {FRAC_BITS{1'b0}}});
		dq_d = RW'(clip_s2[2][CW-2:0]) << QB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			front_s3 <= clip_s2[2] > W_MIN;
			d_s3     <= clip_s2[2][CW-2:0];
			negx_s3  <= clip_s2[0][CW-1];
			negy_s3  <= clip_s2[1][CW-1];
			rx_s3    <= nx_d;
			ry_s3    <= ny_d;
			ovx_s3   <= nx_d >= dq_d;
			ovy_s3   <= ny_d >= dq_d;
			bx_s3    <= behind_scale(clip_s2[0]);
			by_s3    <= behind_scale(clip_s2[1]);
		end
	end

	// division stages: stage j settles quotient bit QB-1-j
	logic                    vd      [QB];
	logic                    frontd  [QB];
	logic                    negxd   [QB];
	logic                    negyd   [QB];
	logic                    ovxd    [QB];
	logic                    ovyd    [QB];
	logic [CW-2:0]           dd      [QB];
	logic [RW-1:0]           rxd     [QB];
	logic [RW-1:0]           ryd     [QB];
	logic [QB-1:0]           qxd     [QB];
	logic [QB-1:0]           qyd     [QB];
	logic signed [OUT_W-1:0] bxd     [QB];
	logic signed [OUT_W-1:0] byd     [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic                    v_i, f_i, nx_i, ny_i, ox_i, oy_i;
		logic [CW-2:0]           d_i;
		logic [RW-1:0]           rx_i, ry_i, dk;
		logic [QB-1:0]           qx_i, qy_i;
		logic signed [OUT_W-1:0] bx_i, by_i;
		if (j == 0) begin : g_first
			assign v_i  = v_s3;    assign f_i  = front_s3;
			assign nx_i = negx_s3; assign ny_i = negy_s3;
			assign ox_i = ovx_s3;  assign oy_i = ovy_s3;
			assign d_i  = d_s3;
			assign rx_i = rx_s3;   assign ry_i = ry_s3;
			assign qx_i = '0;      assign qy_i = '0;
			assign bx_i = bx_s3;   assign by_i = by_s3;
		end else begin : g_next
			assign v_i  = vd[j-1];    assign f_i  = frontd[j-1];
			assign nx_i = negxd[j-1]; assign ny_i = negyd[j-1];
			assign ox_i = ovxd[j-1];  assign oy_i = ovyd[j-1];
			assign d_i  = dd[j-1];
			assign rx_i = rxd[j-1];   assign ry_i = ryd[j-1];
			assign qx_i = qxd[j-1];   assign qy_i = qyd[j-1];
			assign bx_i = bxd[j-1];   assign by_i = byd[j-1];
		end
		assign dk = RW'(d_i) << (QB - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd[j] <= 1'b0;
			else if (adv) vd[j] <= v_i;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				frontd[j] <= f_i;
				negxd[j]  <= nx_i;
				negyd[j]  <= ny_i;
				ovxd[j]   <= ox_i;
				ovyd[j]   <= oy_i;
				dd[j]     <= d_i;
				bxd[j]    <= bx_i;
				byd[j]    <= by_i;
				rxd[j]    <= (rx_i >= dk) ? rx_i - dk : rx_i;
				ryd[j]    <= (ry_i >= dk) ? ry_i - dk : ry_i;
				qxd[j]    <= qx_i | ((rx_i >= dk) ? (QB'(1) << (QB - 1 - j)) : '0);
				qyd[j]    <= qy_i | ((ry_i >= dk) ? (QB'(1) << (QB - 1 - j)) : '0);
			end
		end
	end

	// stage 4: clamp, sign, scale by viewport size
	localparam int L = QB - 1;
	logic [QB-1:0]           qx_c, qy_c;
	logic signed [QB:0]      sx_n, sy_n;
	logic                    v_s4, front_s4;
	logic signed [MW-1:0]    px_s4, py_s4;
	logic signed [OUT_W-1:0] bx_s4, by_s4;
	always_comb begin
		qx_c = (ovxd[L] || qxd[L] > Q_LIM) ? Q_LIM : qxd[L];
		qy_c = (ovyd[L] || qyd[L] > Q_LIM) ? Q_LIM : qyd[L];
		sx_n = negxd[L] ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
		sy_n = negyd[L] ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= vd[L];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			front_s4 <= frontd[L];
			bx_s4    <= bxd[L];
			by_s4    <= byd[L];
			px_s4    <= MW'(sx_n) * MW'($signed({1'b0, sw_q}));
			py_s4    <= MW'(sy_n) * MW'($signed({1'b0, sh_q}));
		end
	end

	// output register: viewport offset, half, floor, saturate
	logic signed [SW-1:0]    one_e, sumx, sumy, hx, hy;
	logic signed [OUT_W-1:0] fx, fy;
	pixel_t                  out_q;
	always_comb begin
		one_e = SW'(1) <<< FRAC_BITS;
		sumx  = (SW'($signed({1'b0, sw_q})) <<< FRAC_BITS) + SW'(px_s4) + one_e;
		sumy  = (SW'($signed({1'b0, sh_q})) <<< FRAC_BITS) - SW'(py_s4) - one_e;
		hx    = sumx >>> 1;
		hy    = sumy >>> 1;
		fx    = (hx > SW'(OUT_MAX)) ? OUT_MAX : (hx < SW'(OUT_MIN)) ? OUT_MIN : hx[OUT_W-1:0];
		fy    = (hy > SW'(OUT_MAX)) ? OUT_MAX : (hy < SW'(OUT_MIN)) ? OUT_MIN : hy[OUT_W-1:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) screen_valid <= 1'b0;
		else if (adv) screen_valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.in_front <= front_s4;
			out_q.screen_x <= front_s4 ? fx : bx_s4;
			out_q.screen_y <= front_s4 ? fy : by_s4;
		end
	end
	assign screen = out_q;

	// remainder left by the last stage is below the divisor for a live quotient
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vd[L] && frontd[L] && !ovxd[L]) |-> (rxd[L] < RW'(dd[L])))
		else $error("division remainder not below divisor");
	// an empty output register always takes a new point
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!screen_valid |-> point_ready)
		else $error("pipe stalled with empty output");
	// clamped quotients never pass the limit
	a_q_lim: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($past(qx_c) <= Q_LIM || !$past(adv)))
		else $error("quotient above clamp");
	// a valid result follows a valid stage-4 beat into the output register
	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4) |=> screen_valid)
		else $error("result lost at output register");

endmodule

[bench/world_to_screen_projection_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for world_to_screen_projection_core: random and directed
// world points, several matrix and viewport settings, randomized idling on both sides.
// Depends on wts_pkg and the core RTL.
module world_to_screen_projection_core_tb;
	import wts_pkg::*;

	localparam int  FB       = 16;
	localparam int  ONE      = 1 << FB;
	// w at or below this raw value means the point is behind the viewer
	localparam int  W_BEHIND = (ONE + 999) / 1000;
	localparam int  LATENCY  = 55;
	localparam int  WDOG_MAX = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  point_valid = 1'b0;
	logic                  point_ready;
	point_t                point = '0;
	logic                  screen_valid;
	logic                  screen_ready = 1'b0;
	pixel_t                screen;

	// predictor copy of the register file
	logic [63:0]      mat_reg [6];
	logic [SCR_W-1:0] view_w;
	logic [SCR_W-1:0] view_h;

	point_t pending_points [$];
	pixel_t expected_pixels [$];
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     mismatches = 0;
	int     points_sent = 0;
	int     pixels_seen = 0;
	int     behind_seen = 0;
	int     quiet_cycles = 0;

	world_to_screen_projection_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.screen_valid(screen_valid), .screen_ready(screen_ready), .screen(screen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one matrix row: floored products, then the translation
	function automatic logic signed [79:0] row_dot(int r, point_t p);
		logic signed [31:0] c0, c1, c2, tr;
		logic signed [63:0] m0, m1, m2;
		logic signed [79:0] s;
		c0 = mat_reg[2*r][31:0];
		c1 = mat_reg[2*r][63:32];
		c2 = mat_reg[2*r+1][31:0];
		tr = mat_reg[2*r+1][63:32];
		m0 = c0 * p.world_x;
		m1 = c1 * p.world_y;
		m2 = c2 * p.world_z;
		m0 = m0 >>> FB;
		m1 = m1 >>> FB;
		m2 = m2 >>> FB;
		s = m0 + m1 + m2 + tr;
		return s;
	endfunction

	// clip / w, truncated toward zero, clamped to 2^49 raw
	function automatic logic signed [79:0] persp_div(logic signed [79:0] c,
	                                               logic signed [79:0] w);
		logic [79:0] a, d, q, r;
		logic        neg;
		neg = c < 0;
		a = neg ? -c : c;
		d = w;
		q = a / d;
		r = a % d;
		if (q >= (80'd1 << (49 - FB))) begin
			q = 80'd1 << 49;
		end else begin
			for (int i = 0; i < FB; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q[0] = 1'b1;
				end
			end
			if (q > (80'd1 << 49)) q = 80'd1 << 49;
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp48(logic signed [79:0] v);
		if (v > OUT_MAX) return OUT_MAX;
		if (v < OUT_MIN) return OUT_MIN;
		return v[OUT_W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] behind_value(logic signed [79:0] c);
		logic signed [79:0] hi, lo;
		hi = BEHIND_HI;
		lo = BEHIND_LO;
		if (c > hi) return OUT_MAX;
		if (c < lo) return OUT_MIN;
		return clamp48(c * BEHIND_SCALE);
	endfunction

	function automatic pixel_t project_point(point_t p);
		logic signed [79:0] cx, cy, w, nx, ny, sw, sh, one_q;
		pixel_t o;
		cx = row_dot(0, p);
		cy = row_dot(1, p);
		w  = row_dot(2, p);
		if (w <= W_BEHIND) begin
			o.in_front = 1'b0;
			o.screen_x = behind_value(cx);
			o.screen_y = behind_value(cy);
		end else begin
			nx = persp_div(cx, w);
			ny = persp_div(cy, w);
			sw = {66'd0, view_w};
			sh = {66'd0, view_h};
			one_q = ONE;
			o.in_front = 1'b1;
			o.screen_x = clamp48((sw * one_q + nx * sw + one_q) >>> 1);
			o.screen_y = clamp48((sh * one_q - ny * sh - one_q) >>> 1);
		end
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s beat %0d: got %h want %h", field, pixels_seen, got, want);
		mismatches++;
	endtask

	// driver: advance to the next pending point when the current beat is taken
	always @(posedge clk) begin
		if (point_valid && point_ready) begin
			expected_pixels.push_back(project_point(point));
			points_sent++;
		end
		if (!point_valid || point_ready) begin
			if (arst_n && pending_points.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				point_valid <= 1'b1;
				point <= pending_points.pop_front();
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	// monitor: stall at random, check each taken beat against the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		screen_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		if (screen_valid && screen_ready) begin
			pixels_seen++;
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected", 64'(screen), 64'd0);
			end else begin
				want = expected_pixels.pop_front();
				if (!want.in_front) behind_seen++;
				if (screen.in_front !== want.in_front)
					report_mismatch("in_front", 64'(screen.in_front), 64'(want.in_front));
				if (screen.screen_x !== want.screen_x)
					report_mismatch("screen_x", 64'(screen.screen_x), 64'(want.screen_x));
				if (screen.screen_y !== want.screen_y)
					report_mismatch("screen_y", 64'(screen.screen_y), 64'(want.screen_y));
			end
		end
	end

	// watchdog: count stuck cycles only while work is outstanding
	always @(posedge clk) begin
		if ((point_valid && point_ready) || (screen_valid && screen_ready) ||
		    (pending_points.size() == 0 && expected_pixels.size() == 0 && !point_valid)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding", expected_pixels.size());
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic drain();
		wait (pending_points.size() == 0 && !point_valid && expected_pixels.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_SCR_W) mat_reg[idx] = data;
		else if (idx == REG_SCR_W) view_w = data[SCR_W-1:0];
		else if (idx == REG_SCR_H) view_h = data[SCR_W-1:0];
	endtask

	function automatic logic [31:0] coef(int lo, int hi);
		return 32'($urandom_range(hi - lo) + lo);
	endfunction

	// full-range matrix, or a camera-like one whose w row follows z
	task automatic load_matrix(bit wild);
		if (wild) begin
			for (int r = 0; r < 6; r++)
				write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
		end else begin
			write_reg(REG_ROW0_LO, {coef(-ONE/2, ONE/2), coef(ONE/2, 3*ONE)});
			write_reg(REG_ROW0_HI, {coef(-2*ONE, 2*ONE), coef(-ONE/4, ONE/4)});
			write_reg(REG_ROW1_LO, {coef(ONE/2, 3*ONE), coef(-ONE/2, ONE/2)});
			write_reg(REG_ROW1_HI, {coef(-2*ONE, 2*ONE), coef(-ONE/4, ONE/4)});
			write_reg(REG_WROW_LO, {coef(-ONE/64, ONE/64), coef(-ONE/64, ONE/64)});
			write_reg(REG_WROW_HI, {coef(-ONE/2, ONE/2), coef(ONE/2, 2*ONE)});
		end
		// an index past the register list must leave everything alone
		write_reg(CFG_IDX_W'(REG_SCR_H + 1 + $urandom_range(7)), {$urandom, $urandom});
	endtask

	task automatic queue_random_points(int n);
		point_t p;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 2) begin
				p = {$urandom, $urandom, $urandom};
			end else begin
				p.world_x = $signed(coef(-8*ONE, 8*ONE));
				p.world_y = $signed(coef(-8*ONE, 8*ONE));
				// mostly in front, sometimes behind or right at the behind threshold
				case ($urandom_range(9))
					0: p.world_z = $signed(coef(-4*ONE, 0));
					1: p.world_z = $signed(coef(W_BEHIND - 3, W_BEHIND + 3));
					default: p.world_z = $signed(coef(ONE/8, 16*ONE));
				endcase
			end
			pending_points.push_back(p);
		end
	endtask

	int scr_w_set [9] = '{1920, 0, 16383, 8192, 1, 0, 0, 0, 0};
	int scr_h_set [9] = '{1080, 0, 16383, 8192, 1, 0, 0, 0, 0};

	initial begin
		for (int r = 0; r < 6; r++) mat_reg[r] = '0;
		view_w = SCR_W_RST;
		view_h = SCR_H_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset matrix: w is zero, so everything lands behind the viewer
		pending_points.push_back('{32'sd12345, -32'sd777, 32'sd65536});
		pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
		drain();

		// identity camera: w equals z
		write_reg(REG_ROW0_LO, {32'd0, 32'(ONE)});
		write_reg(REG_ROW0_HI, 64'd0);
		write_reg(REG_ROW1_LO, {32'(ONE), 32'd0});
		write_reg(REG_ROW1_HI, 64'd0);
		write_reg(REG_WROW_LO, 64'd0);
		write_reg(REG_WROW_HI, {32'd0, 32'(ONE)});
		pending_points.push_back('{32'sd0, 32'sd0, 32'(ONE)});
		pending_points.push_back('{32'(ONE), 32'(ONE), 32'(ONE)});
		pending_points.push_back('{-32'(ONE), -32'(ONE), 32'(2*ONE)});
		pending_points.push_back('{32'(ONE), -32'(ONE), 32'(W_BEHIND)});
		pending_points.push_back('{32'(ONE), -32'(ONE), 32'(W_BEHIND + 1)});
		pending_points.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'(W_BEHIND + 1)});
		pending_points.push_back('{32'h80000000, 32'h80000000, 32'(W_BEHIND + 1)});
		pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
		pending_points.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
		pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h80000000});
		pending_points.push_back('{32'sd100, -32'sd100, 32'sd0});
		pending_points.push_back('{32'sd14074, -32'sd14075, -32'sd1});
		pending_points.push_back('{32'sd1, -32'sd1, 32'h7FFFFFFF});
		drain();
		write_reg(REG_SCR_W, 64'd0);
		write_reg(REG_SCR_H, 64'hFFFF_FFFF_FFFF_FFFF);
		pending_points.push_back('{32'(ONE/2), -32'(ONE/2), 32'(ONE)});
		pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'(W_BEHIND + 1)});
		drain();

		// random part: nine settings, three per idling profile
		for (int k = 0; k < 9; k++) begin
			case (k / 3)
				0: begin send_idle_pct = 29; recv_stall_pct = 68; end
				1: begin send_idle_pct = 68; recv_stall_pct = 29; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			load_matrix(k % 4 == 3);
			write_reg(REG_SCR_W, scr_w_set[k] != 0 || k < 5 ?
			          64'(scr_w_set[k]) : 64'($urandom_range(16383)));
			write_reg(REG_SCR_H, scr_h_set[k] != 0 || k < 5 ?
			          64'(scr_h_set[k]) : 64'($urandom_range(16383)));
			queue_random_points(120);
			drain();
		end

		$display("covered %0d points over nine random settings plus directed cases", points_sent);
		$display("checked %0d results, %0d behind the viewer, %0d mismatches",
		         pixels_seen, behind_seen, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[world_to_screen_projection_core.f]
rtl/core/wts_pkg.sv
rtl/core/world_to_screen_projection_core.sv
bench/world_to_screen_projection_core_tb.sv
